// File: hw/rtl/rlit_pkg.sv
package rlit_pkg;

  localparam int unsigned LogDepthDefault = 1024;

  localparam int unsigned IdxW    = 64;
  localparam int unsigned TermW   = 64;
  localparam int unsigned KindW   = 8;
  localparam int unsigned HandleW = 32;
  localparam int unsigned ReqW    = 3;
  localparam int unsigned StatW   = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_APPEND_AT = 3'd1,
    REQ_TRUNCATE  = 3'd2,
    REQ_COMPACT   = 3'd3,
    REQ_LOOKUP    = 3'd4
  } req_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_GAP   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_TRUNC = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [TermW-1:0]   term;
    logic [KindW-1:0]   kind;
    logic [HandleW-1:0] handle;
  } entry_t;

endpackage

// File: hw/rtl/rlit_store.sv
module rlit_store #(
  parameter int unsigned LogDepth = rlit_pkg::LogDepthDefault,
  localparam int unsigned AW = $clog2(LogDepth)
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  rlit_pkg::entry_t wr_data_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output rlit_pkg::entry_t rd_data_o
);
  import rlit_pkg::*;

  entry_t mem_q [LogDepth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/rlit_ctrl.sv
module rlit_ctrl #(
  parameter int unsigned LogDepth = rlit_pkg::LogDepthDefault,
  localparam int unsigned AW = $clog2(LogDepth)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [rlit_pkg::ReqW-1:0]     req_type_i,
  input  logic [rlit_pkg::IdxW-1:0]     entry_index_i,
  input  logic [rlit_pkg::TermW-1:0]    entry_term_i,
  input  logic [rlit_pkg::KindW-1:0]    command_kind_i,
  input  logic [rlit_pkg::HandleW-1:0]  payload_handle_i,
  output logic                          result_valid_o,
  output logic [rlit_pkg::StatW-1:0]    status_o,
  output logic [rlit_pkg::IdxW-1:0]     assigned_index_o,
  output logic [rlit_pkg::IdxW-1:0]     last_index_o,
  output logic [rlit_pkg::TermW-1:0]    last_term_o,
  output logic [rlit_pkg::TermW-1:0]    lookup_term_o,
  output logic                          lookup_found_o,
  output logic [rlit_pkg::KindW-1:0]    lookup_kind_o,
  output logic [rlit_pkg::HandleW-1:0]  lookup_handle_o,
  output logic                          wr_en_o,
  output logic [AW-1:0]                 wr_addr_o,
  output rlit_pkg::entry_t              wr_data_o,
  output logic                          rd_en_o,
  output logic [AW-1:0]                 rd_addr_o,
  input  rlit_pkg::entry_t              rd_data_i
);
  import rlit_pkg::*;

  localparam int unsigned CW = $clog2(LogDepth + 1);
  localparam int unsigned SW = CW + 1;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(off);
    if (sum >= SW'(LogDepth)) begin
      sum = sum - SW'(LogDepth);
    end
    return sum[AW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [ReqW-1:0]    req_q;
  logic [IdxW-1:0]    idx_q;
  logic [TermW-1:0]   term_q;
  logic [KindW-1:0]   kind_q;
  logic [HandleW-1:0] handle_q;

  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IdxW-1:0]  snap_idx_q, snap_idx_d;
  logic [TermW-1:0] snap_term_q, snap_term_d;
  logic [IdxW-1:0]  last_q, last_d;
  logic [TermW-1:0] last_term_q, last_term_d;

  status_e          status_q, status_d;
  logic [IdxW-1:0]  assigned_q, assigned_d;
  logic [TermW-1:0] lk_term_q, lk_term_d;
  logic             found_q, found_d;
  logic             lt_mem_q, lt_mem_d;

  logic             accept;
  logic             full;
  logic             last_max;
  logic [IdxW-1:0]  last_inc;
  logic [IdxW-1:0]  clamp;
  logic [CW-1:0]    drop;
  logic [CW-1:0]    trunc_cnt;
  logic [CW-1:0]    look_off;

  assign busy_o = (state_q == S_EXEC);
  assign accept = start_i && !busy_o;

  assign full      = (count_q == CW'(LogDepth));
  assign last_max  = &last_q;
  assign last_inc  = last_q + IdxW'(1);
  assign clamp     = (idx_q > last_q) ? last_q : idx_q;
  assign drop      = CW'(clamp - snap_idx_q);
  assign trunc_cnt = CW'(idx_q - snap_idx_q);
  assign look_off  = CW'(idx_q - snap_idx_q - IdxW'(1));

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    snap_idx_d  = snap_idx_q;
    snap_term_d = snap_term_q;
    last_d      = last_q;
    last_term_d = last_term_q;
    status_d    = status_q;
    assigned_d  = assigned_q;
    lk_term_d   = lk_term_q;
    found_d     = found_q;
    lt_mem_d    = lt_mem_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = slot_of(head_q, count_q);
    wr_data_o   = '{term: term_q, kind: kind_q, handle: handle_q};
    rd_en_o     = 1'b0;
    rd_addr_o   = slot_of(head_q, look_off);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d    = S_RESP;
        status_d   = STAT_OK;
        assigned_d = '0;
        lk_term_d  = '0;
        found_d    = 1'b0;
        lt_mem_d   = 1'b0;
        unique case (req_q)
          REQ_APPEND, REQ_APPEND_AT: begin
            if (req_q == REQ_APPEND_AT && (last_max || idx_q != last_inc)) begin
              status_d = STAT_GAP;
            end else if (full || last_max) begin
              status_d = STAT_FULL;
            end else begin
              wr_en_o     = 1'b1;
              count_d     = count_q + CW'(1);
              last_d      = last_inc;
              last_term_d = term_q;
              assigned_d  = last_inc;
            end
          end
          REQ_TRUNCATE: begin
            if (idx_q >= last_q) begin
              status_d = STAT_OK;
            end else if (idx_q < snap_idx_q) begin
              status_d = STAT_TRUNC;
            end else begin
              count_d = trunc_cnt;
              last_d  = idx_q;
              if (trunc_cnt == '0) begin
                last_term_d = snap_term_q;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = slot_of(head_q, trunc_cnt - CW'(1));
                lt_mem_d  = 1'b1;
              end
            end
          end
          REQ_COMPACT: begin
            if (idx_q > snap_idx_q) begin
              head_d      = slot_of(head_q, drop);
              count_d     = count_q - drop;
              snap_idx_d  = clamp;
              snap_term_d = term_q;
              if (count_q == drop) begin
                last_term_d = term_q;
              end
            end
          end
          REQ_LOOKUP: begin
            if (idx_q == '0) begin
              lk_term_d = '0;
            end else if (idx_q == snap_idx_q) begin
              lk_term_d = snap_term_q;
            end else if (idx_q > snap_idx_q && idx_q <= last_q) begin
              rd_en_o = 1'b1;
              found_d = 1'b1;
            end
          end
          default: begin
            status_d = STAT_OK;
          end
        endcase
      end
      S_RESP: begin
        if (lt_mem_q) begin
          last_term_d = rd_data_i.term;
        end
        state_d = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      snap_idx_q  <= '0;
      snap_term_q <= '0;
      last_q      <= '0;
      last_term_q <= '0;
      lt_mem_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      snap_idx_q  <= snap_idx_d;
      snap_term_q <= snap_term_d;
      last_q      <= last_d;
      last_term_q <= last_term_d;
      lt_mem_q    <= lt_mem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    assigned_q <= assigned_d;
    lk_term_q  <= lk_term_d;
    found_q    <= found_d;
    if (accept) begin
      req_q    <= req_type_i;
      idx_q    <= entry_index_i;
      term_q   <= entry_term_i;
      kind_q   <= command_kind_i;
      handle_q <= payload_handle_i;
    end
  end

  assign result_valid_o   = (state_q == S_RESP);
  assign status_o         = status_q;
  assign assigned_index_o = assigned_q;
  assign last_index_o     = last_q;
  assign last_term_o      = lt_mem_q ? rd_data_i.term : last_term_q;
  assign lookup_found_o   = found_q;
  assign lookup_term_o    = found_q ? rd_data_i.term : lk_term_q;
  assign lookup_kind_o    = found_q ? rd_data_i.kind : '0;
  assign lookup_handle_o  = found_q ? rd_data_i.handle : '0;

endmodule

// File: hw/rtl/replicated_log_index_table.sv
// result: strobe raised in the respond state, which follows the execute state
// intake: busy_o is high only in the execute state; respond can take the
//   next item. Each item makes one pass through the single-port-read entry memory
// reset: asynchronous, active low; log empty, snapshot index and term zero,
//   entry memory contents undefined; results cannot be stalled by the receiver
module replicated_log_index_table #(
  parameter int unsigned LOG_DEPTH = rlit_pkg::LogDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [rlit_pkg::ReqW-1:0]     req_type_i,
  input  logic [rlit_pkg::IdxW-1:0]     entry_index_i,
  input  logic [rlit_pkg::TermW-1:0]    entry_term_i,
  input  logic [rlit_pkg::KindW-1:0]    command_kind_i,
  input  logic [rlit_pkg::HandleW-1:0]  payload_handle_i,
  output logic                          result_valid_o,
  output logic [rlit_pkg::StatW-1:0]    status_o,
  output logic [rlit_pkg::IdxW-1:0]     assigned_index_o,
  output logic [rlit_pkg::IdxW-1:0]     last_index_o,
  output logic [rlit_pkg::TermW-1:0]    last_term_o,
  output logic [rlit_pkg::TermW-1:0]    lookup_term_o,
  output logic                          lookup_found_o,
  output logic [rlit_pkg::KindW-1:0]    lookup_kind_o,
  output logic [rlit_pkg::HandleW-1:0]  lookup_handle_o
);
  import rlit_pkg::*;

  localparam int unsigned AW = $clog2(LOG_DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  rlit_ctrl #(
    .LogDepth(LOG_DEPTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .req_type_i      (req_type_i),
    .entry_index_i   (entry_index_i),
    .entry_term_i    (entry_term_i),
    .command_kind_i  (command_kind_i),
    .payload_handle_i(payload_handle_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .assigned_index_o(assigned_index_o),
    .last_index_o    (last_index_o),
    .last_term_o     (last_term_o),
    .lookup_term_o   (lookup_term_o),
    .lookup_found_o  (lookup_found_o),
    .lookup_kind_o   (lookup_kind_o),
    .lookup_handle_o (lookup_handle_o),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data)
  );

  rlit_store #(
    .LogDepth(LOG_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

endmodule

// File: hw/rtl/rlit_checker.sv
module rlit_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          result_valid_o,
  input logic [rlit_pkg::StatW-1:0]    status_o,
  input logic [rlit_pkg::IdxW-1:0]     assigned_index_o,
  input logic                          lookup_found_o
);
  import rlit_pkg::*;

  // accepted item passes the execute state, then is answered in the respond state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> ##1 result_valid_o)
    else $error("result strobe missing after accepted item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o && !$past(result_valid_o))
    else $error("result strobe overlaps execute or repeats");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result without an executed item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != STAT_OK |-> assigned_index_o == '0)
    else $error("index assigned on failed request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && lookup_found_o |-> status_o == STAT_OK)
    else $error("lookup hit with error status");

endmodule

bind replicated_log_index_table rlit_checker u_rlit_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .result_valid_o  (result_valid_o),
  .status_o        (status_o),
  .assigned_index_o(assigned_index_o),
  .lookup_found_o  (lookup_found_o)
);

// File: tb/log_index_checker.sv
module log_index_checker #(
  parameter int unsigned LOG_DEPTH = rlit_pkg::LogDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [rlit_pkg::ReqW-1:0]     req_type_i,
  input  logic [rlit_pkg::IdxW-1:0]     entry_index_i,
  input  logic [rlit_pkg::TermW-1:0]    entry_term_i,
  input  logic [rlit_pkg::KindW-1:0]    command_kind_i,
  input  logic [rlit_pkg::HandleW-1:0]  payload_handle_i,
  input  logic                          result_valid_i,
  input  logic [rlit_pkg::StatW-1:0]    status_i,
  input  logic [rlit_pkg::IdxW-1:0]     assigned_index_i,
  input  logic [rlit_pkg::IdxW-1:0]     last_index_i,
  input  logic [rlit_pkg::TermW-1:0]    last_term_i,
  input  logic [rlit_pkg::TermW-1:0]    lookup_term_i,
  input  logic                          lookup_found_i,
  input  logic [rlit_pkg::KindW-1:0]    lookup_kind_i,
  input  logic [rlit_pkg::HandleW-1:0]  lookup_handle_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   pending_o
);
  import rlit_pkg::*;

  typedef struct packed {
    status_e             status;
    logic [IdxW-1:0]     assigned;
    logic [IdxW-1:0]     last_index;
    logic [TermW-1:0]    last_term;
    logic [TermW-1:0]    lookup_term;
    logic                found;
    logic [KindW-1:0]    lookup_kind;
    logic [HandleW-1:0]  lookup_handle;
  } log_reply_t;

  logic [TermW-1:0]   ring_term   [LOG_DEPTH];
  logic [KindW-1:0]   ring_kind   [LOG_DEPTH];
  logic [HandleW-1:0] ring_handle [LOG_DEPTH];
  int unsigned        ring_head;
  int unsigned        live_count;
  logic [IdxW-1:0]    snap_index;
  logic [TermW-1:0]   snap_term;

  log_reply_t pending_replies [$];

  function automatic int unsigned slot_at(int unsigned off);
    return (ring_head + off) % LOG_DEPTH;
  endfunction

  function automatic void append_entry(logic [TermW-1:0] term, logic [KindW-1:0] kind,
                                       logic [HandleW-1:0] handle);
    int unsigned s;
    s = slot_at(live_count);
    ring_term[s] = term;
    ring_kind[s] = kind;
    ring_handle[s] = handle;
    live_count++;
  endfunction

  function automatic log_reply_t apply_log_request(logic [ReqW-1:0] req, logic [IdxW-1:0] idx,
                                                   logic [TermW-1:0] term,
                                                   logic [KindW-1:0] kind,
                                                   logic [HandleW-1:0] handle);
    log_reply_t r;
    logic [IdxW-1:0] last;
    logic [IdxW-1:0] cut;
    int unsigned drop;
    int unsigned s;
    r = '0;
    r.status = STAT_OK;
    last = snap_index + 64'(live_count);
    case (req)
      REQ_APPEND: begin
        if (live_count >= LOG_DEPTH || last == '1) begin
          r.status = STAT_FULL;
        end else begin
          append_entry(term, kind, handle);
          r.assigned = last + 1;
        end
      end
      REQ_APPEND_AT: begin
        if (last == '1 || idx != last + 1) begin
          r.status = STAT_GAP;
        end else if (live_count >= LOG_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          append_entry(term, kind, handle);
          r.assigned = idx;
        end
      end
      REQ_TRUNCATE: begin
        if (idx >= last) begin
          r.status = STAT_OK;
        end else if (idx < snap_index) begin
          r.status = STAT_TRUNC;
        end else begin
          live_count = 32'(idx - snap_index);
        end
      end
      REQ_COMPACT: begin
        if (idx > snap_index) begin
          cut = (idx > last) ? last : idx;
          drop = 32'(cut - snap_index);
          ring_head = slot_at(drop);
          live_count -= drop;
          snap_index = cut;
          snap_term = term;
        end
      end
      REQ_LOOKUP: begin
        if (idx == '0) begin
          r.lookup_term = '0;
        end else if (idx == snap_index) begin
          r.lookup_term = snap_term;
        end else if (idx > snap_index && idx <= last) begin
          s = slot_at(32'(idx - snap_index - 1));
          r.lookup_term = ring_term[s];
          r.found = 1'b1;
          r.lookup_kind = ring_kind[s];
          r.lookup_handle = ring_handle[s];
        end
      end
      default: ;
    endcase
    r.last_index = snap_index + 64'(live_count);
    r.last_term = (live_count == 0) ? snap_term : ring_term[slot_at(live_count - 1)];
    return r;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    log_reply_t want;
    if (!rst_ni) begin
      ring_head = 0;
      live_count = 0;
      snap_index = '0;
      snap_term = '0;
      pending_replies.delete();
      pending_o = 0;
      fail_cnt_o = 0;
    end else begin
      if (result_valid_i === 1'b1) begin
        if (pending_replies.size() == 0) begin
          $error("result with no item outstanding");
          fail_cnt_o++;
        end else begin
          want = pending_replies.pop_front();
          check_field("status", 64'(want.status), 64'(status_i));
          check_field("assigned_index", want.assigned, assigned_index_i);
          check_field("last_index", want.last_index, last_index_i);
          check_field("last_term", want.last_term, last_term_i);
          check_field("lookup_term", want.lookup_term, lookup_term_i);
          check_field("lookup_found", 64'(want.found), 64'(lookup_found_i));
          check_field("lookup_kind", 64'(want.lookup_kind), 64'(lookup_kind_i));
          check_field("lookup_handle", 64'(want.lookup_handle), 64'(lookup_handle_i));
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        pending_replies.push_back(apply_log_request(req_type_i, entry_index_i, entry_term_i,
                                                    command_kind_i, payload_handle_i));
      end
      pending_o = pending_replies.size();
    end
  end

endmodule

// File: tb/tb.sv
module tb;
  import rlit_pkg::*;

  localparam int unsigned Depth = LogDepthDefault;
  localparam int unsigned CycleLimit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [ReqW-1:0]     req_type_i = '0;
  logic [IdxW-1:0]     entry_index_i = '0;
  logic [TermW-1:0]    entry_term_i = '0;
  logic [KindW-1:0]    command_kind_i = '0;
  logic [HandleW-1:0]  payload_handle_i = '0;
  logic                result_valid_o;
  logic [StatW-1:0]    status_o;
  logic [IdxW-1:0]     assigned_index_o;
  logic [IdxW-1:0]     last_index_o;
  logic [TermW-1:0]    last_term_o;
  logic [TermW-1:0]    lookup_term_o;
  logic                lookup_found_o;
  logic [KindW-1:0]    lookup_kind_o;
  logic [HandleW-1:0]  lookup_handle_o;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned cycles = 0;
  bit          idle_on = 1'b0;

  // rough view of the log window, used only to aim indices and to know when the ring is full
  logic [IdxW-1:0] trk_snap = '0;
  int unsigned     trk_count = 0;

  always #5 clk_i = ~clk_i;

  replicated_log_index_table u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .req_type_i,
    .entry_index_i,
    .entry_term_i,
    .command_kind_i,
    .payload_handle_i,
    .result_valid_o,
    .status_o,
    .assigned_index_o,
    .last_index_o,
    .last_term_o,
    .lookup_term_o,
    .lookup_found_o,
    .lookup_kind_o,
    .lookup_handle_o
  );

  log_index_checker u_check (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i           (busy_o),
    .req_type_i,
    .entry_index_i,
    .entry_term_i,
    .command_kind_i,
    .payload_handle_i,
    .result_valid_i   (result_valid_o),
    .status_i         (status_o),
    .assigned_index_i (assigned_index_o),
    .last_index_i     (last_index_o),
    .last_term_i      (last_term_o),
    .lookup_term_i    (lookup_term_o),
    .lookup_found_i   (lookup_found_o),
    .lookup_kind_i    (lookup_kind_o),
    .lookup_handle_i  (lookup_handle_o),
    .fail_cnt_o       (fail_cnt),
    .pending_o        (pending_cnt)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IdxW-1:0] trk_last();
    return trk_snap + 64'(trk_count);
  endfunction

  // index in or just around the held window
  function automatic logic [IdxW-1:0] near_index();
    logic [IdxW-1:0] base;
    base = (trk_snap >= 2) ? trk_snap - 2 : '0;
    return base + 64'($urandom_range(0, 32'(trk_last() + 2 - base)));
  endfunction

  task automatic issue(logic [ReqW-1:0] req, logic [IdxW-1:0] idx, logic [TermW-1:0] term,
                       logic [KindW-1:0] kind, logic [HandleW-1:0] handle);
    logic [IdxW-1:0] last;
    logic [IdxW-1:0] cut;
    start_i <= 1'b1;
    req_type_i <= req;
    entry_index_i <= idx;
    entry_term_i <= term;
    command_kind_i <= kind;
    payload_handle_i <= handle;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    last = trk_last();
    case (req)
      REQ_APPEND: if (trk_count < Depth) trk_count++;
      REQ_APPEND_AT: if (idx == last + 1 && trk_count < Depth) trk_count++;
      REQ_TRUNCATE: if (idx < last && idx >= trk_snap) trk_count = 32'(idx - trk_snap);
      REQ_COMPACT: begin
        if (idx > trk_snap) begin
          cut = (idx > last) ? last : idx;
          trk_count -= 32'(cut - trk_snap);
          trk_snap = cut;
        end
      end
      default: ;
    endcase
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [IdxW-1:0] idx;
    pick = $urandom_range(0, 99);
    idx = ($urandom_range(0, 9) == 0) ? rand64() : near_index();
    if (pick < 35) begin
      issue(REQ_APPEND, rand64(), rand64(), 8'($urandom), $urandom);
    end else if (pick < 55) begin
      if ($urandom_range(0, 4) != 0) idx = trk_last() + 1;
      issue(REQ_APPEND_AT, idx, rand64(), 8'($urandom), $urandom);
    end else if (pick < 63) begin
      issue(REQ_TRUNCATE, idx, rand64(), 8'($urandom), $urandom);
    end else if (pick < 72) begin
      if ($urandom_range(0, 4) != 0) idx = trk_snap + 64'($urandom_range(0, trk_count / 2 + 1));
      issue(REQ_COMPACT, idx, rand64(), 8'($urandom), $urandom);
    end else if (pick < 95) begin
      issue(REQ_LOOKUP, idx, rand64(), 8'($urandom), $urandom);
    end else begin
      issue(3'($urandom_range(5, 7)), rand64(), rand64(), 8'($urandom), $urandom);
    end
  endtask

  task automatic fill_ring();
    while (trk_count < Depth) begin
      if ($urandom_range(0, 1) == 0) begin
        issue(REQ_APPEND, rand64(), rand64(), 8'($urandom), $urandom);
      end else begin
        issue(REQ_APPEND_AT, trk_last() + 1, rand64(), 8'($urandom), $urandom);
      end
    end
    issue(REQ_APPEND, rand64(), rand64(), 8'($urandom), $urandom);
    issue(REQ_APPEND, rand64(), rand64(), 8'($urandom), $urandom);
    issue(REQ_APPEND_AT, trk_last() + 1, rand64(), 8'($urandom), $urandom);
    issue(REQ_APPEND_AT, trk_last() + 2, rand64(), 8'($urandom), $urandom);
    issue(REQ_LOOKUP, trk_last(), '0, '0, '0);
    issue(REQ_LOOKUP, trk_snap + 1, '0, '0, '0);
    issue(REQ_COMPACT, trk_last() - 8, rand64(), 8'($urandom), $urandom);
  endtask

  initial begin
    int unsigned n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty log, extremes, gaps, lookups, truncate and compact corners, unused request codes
    issue(REQ_LOOKUP, '0, '1, '1, '1);
    issue(REQ_APPEND, '1, '1, 8'hff, '1);
    issue(REQ_APPEND, '0, '0, '0, '0);
    issue(REQ_APPEND_AT, 64'd3, 64'h5, 8'h5a, 32'h1234_5678);
    issue(REQ_APPEND_AT, 64'd5, 64'h6, 8'h11, 32'h1);
    issue(REQ_APPEND_AT, '1, 64'h6, 8'h11, 32'h1);
    issue(REQ_APPEND_AT, '0, 64'h6, 8'h11, 32'h1);
    issue(REQ_LOOKUP, 64'd1, '0, '0, '0);
    issue(REQ_LOOKUP, 64'd3, '0, '0, '0);
    issue(REQ_LOOKUP, 64'd4, '0, '0, '0);
    issue(REQ_LOOKUP, '1, '0, '0, '0);
    issue(REQ_TRUNCATE, 64'd3, '0, '0, '0);
    issue(REQ_TRUNCATE, '1, '0, '0, '0);
    issue(REQ_TRUNCATE, 64'd2, '0, '0, '0);
    issue(REQ_COMPACT, 64'd1, 64'h7, '0, '0);
    issue(REQ_LOOKUP, 64'd1, '0, '0, '0);
    issue(REQ_TRUNCATE, 64'd0, '0, '0, '0);
    issue(REQ_COMPACT, 64'd0, 64'h9, '0, '0);
    issue(REQ_COMPACT, 64'd1, 64'h9, '0, '0);
    issue(REQ_APPEND, '0, 64'h8, 8'h80, 32'h8000_0000);
    issue(REQ_COMPACT, '1, '1, '0, '0);
    issue(REQ_LOOKUP, trk_snap, '0, '0, '0);
    issue(REQ_LOOKUP, trk_snap + 1, '0, '0, '0);
    issue(3'd5, '1, '1, '1, '1);
    issue(3'd6, '0, '0, '0, '0);
    issue(3'd7, '1, '0, '1, '0);
    issue(REQ_TRUNCATE, trk_snap, '0, '0, '0);
    drain_results();

    for (n = 0; n < 700; n++) begin
      if (n % 40 == 0) idle_on = (n < 600) && ($urandom_range(0, 2) != 0);
      if (n == 300) begin
        drain_results();
        fill_ring();
      end
      random_item();
    end

    drain_results();
    repeat (6) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rlit_pkg.sv
hw/rtl/rlit_store.sv
hw/rtl/rlit_ctrl.sv
hw/rtl/replicated_log_index_table.sv
hw/rtl/rlit_checker.sv
tb/log_index_checker.sv
tb/tb.sv
